// ----- design/cts_pkg.sv -----
package cts_pkg;

  // series format
  localparam int MAX_TERMS     = 32;
  localparam int SUM_FRAC_BITS = 40;
  localparam int TOL_FRAC_BITS = 40;
  localparam int SQ_FRAC_BITS  = 56;

  // field widths
  localparam int ANGLE_W = 32;
  localparam int TOL_W   = 48;
  localparam int SUM_W   = 64;
  localparam int TERMS_W = 7;

  // term magnitude and square of the angle, both unsigned
  localparam int MAG_W  = 63;
  localparam int OPND_W = 64;
  localparam int PROD_W = 2 * OPND_W;
  localparam int HALF_W = OPND_W / 2;

  // divider: numerator is the product shifted down by the square's fraction bits
  localparam int NUM_W      = 2 * MAG_W - SQ_FRAC_BITS;
  localparam int QUOT_W     = 64;
  localparam int NUM_HI_W   = NUM_W - QUOT_W;
  localparam int DEN_W      = 14;
  localparam int DIV_BITS   = 4;
  localparam int DIV_STEPS  = QUOT_W / DIV_BITS;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  // tolerance alignment to the sum format
  localparam int THR_UP = (SUM_FRAC_BITS >= TOL_FRAC_BITS) ? SUM_FRAC_BITS - TOL_FRAC_BITS : 0;
  localparam int THR_DN = (SUM_FRAC_BITS >= TOL_FRAC_BITS) ? 0 : TOL_FRAC_BITS - SUM_FRAC_BITS;

  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1099512);
  localparam logic [MAG_W-1:0] MAG_ONE   = MAG_W'(1) << SUM_FRAC_BITS;
  localparam logic [MAG_W-1:0] MAG_MAX   = {MAG_W{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ,
    ST_CHECK,
    ST_MUL,
    ST_DIV,
    ST_ADD,
    ST_FIN
  } cts_state_t;

endpackage

// ----- design/cts_mul.sv -----
module cts_mul (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [cts_pkg::OPND_W-1:0]  a,
  input  logic [cts_pkg::OPND_W-1:0]  b,
  output logic                        done,
  output logic [cts_pkg::PROD_W-1:0]  product
);

  // four 32x32 partial products, one per cycle, each accumulated in the following cycle
  logic                        busy_r;
  logic                        done_r;
  logic [2:0]                  step_r;
  logic                        pp_vld_r;
  logic [1:0]                  pp_sh_r;
  logic [cts_pkg::OPND_W-1:0]  a_r;
  logic [cts_pkg::OPND_W-1:0]  b_r;
  logic [cts_pkg::OPND_W-1:0]  pp_r;
  logic [cts_pkg::PROD_W-1:0]  acc_r;
  logic [cts_pkg::HALF_W-1:0]  a_half;
  logic [cts_pkg::HALF_W-1:0]  b_half;
  logic [cts_pkg::OPND_W-1:0]  pp_nxt;
  logic [cts_pkg::PROD_W-1:0]  pp_ext;

  always_comb begin
    a_half = step_r[1] ? a_r[cts_pkg::OPND_W-1:cts_pkg::HALF_W] : a_r[cts_pkg::HALF_W-1:0];
    b_half = step_r[0] ? b_r[cts_pkg::OPND_W-1:cts_pkg::HALF_W] : b_r[cts_pkg::HALF_W-1:0];
  end

  // full-width slice product
  assign pp_nxt = a_half * b_half;

  always_comb begin
    unique case (pp_sh_r)
      2'd0:    pp_ext = cts_pkg::PROD_W'(pp_r);
      2'd1:    pp_ext = cts_pkg::PROD_W'(pp_r) << cts_pkg::HALF_W;
      default: pp_ext = cts_pkg::PROD_W'(pp_r) << (2 * cts_pkg::HALF_W);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      done_r   <= 1'b0;
      step_r   <= 3'd0;
      pp_vld_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r   <= 1'b1;
        step_r   <= 3'd0;
        pp_vld_r <= 1'b0;
      end else if (busy_r) begin
        if (step_r != 3'd4) begin
          step_r   <= step_r + 3'd1;
          pp_vld_r <= 1'b1;
        end else begin
          pp_vld_r <= 1'b0;
          if (pp_vld_r) begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
    end else if (busy_r) begin
      if (step_r != 3'd4) begin
        pp_r    <= pp_nxt;
        pp_sh_r <= 2'(step_r[1]) + 2'(step_r[0]);
      end
      if (pp_vld_r) begin
        acc_r <= acc_r + pp_ext;
      end
    end
  end

  assign done    = done_r;
  assign product = acc_r;

endmodule

// ----- design/cts_div.sv -----
module cts_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [cts_pkg::NUM_W-1:0]   num,
  input  logic [cts_pkg::DEN_W-1:0]   den,
  output logic                        done,
  output logic [cts_pkg::MAG_W-1:0]   quot
);

  // restoring division, DIV_BITS quotient bits per cycle, saturating result
  logic                           busy_r;
  logic                           done_r;
  logic [cts_pkg::DIV_CNT_W-1:0]  cnt_r;
  logic                           sat_r;
  logic [cts_pkg::DEN_W-1:0]      den_r;
  logic [cts_pkg::DEN_W-1:0]      rem_r;
  logic [cts_pkg::DEN_W-1:0]      rem_nxt;
  logic [cts_pkg::QUOT_W-1:0]     work_r;
  logic [cts_pkg::QUOT_W-1:0]     work_nxt;
  logic [cts_pkg::NUM_HI_W-1:0]   num_hi;

  assign num_hi = num[cts_pkg::NUM_W-1:cts_pkg::QUOT_W];

  always_comb begin
    logic [cts_pkg::DEN_W:0] t;
    rem_nxt  = rem_r;
    work_nxt = work_r;
    for (int i = 0; i < cts_pkg::DIV_BITS; i++) begin
      t        = {rem_nxt, work_nxt[cts_pkg::QUOT_W-1]};
      work_nxt = work_nxt << 1;
      if (t >= {1'b0, den_r}) begin
        rem_nxt     = cts_pkg::DEN_W'(t - {1'b0, den_r});
        work_nxt[0] = 1'b1;
      end else begin
        rem_nxt = t[cts_pkg::DEN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= cts_pkg::DIV_CNT_W'(cts_pkg::DIV_STEPS - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // quotient would not fit in 64 bits
      sat_r  <= cts_pkg::DEN_W'(num_hi) >= den;
      den_r  <= den;
      rem_r  <= cts_pkg::DEN_W'(num_hi);
      work_r <= num[cts_pkg::QUOT_W-1:0];
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      work_r <= work_nxt;
    end
  end

  assign done = done_r;
  assign quot = (sat_r || work_r[cts_pkg::QUOT_W-1]) ? cts_pkg::MAG_MAX
                                                      : work_r[cts_pkg::MAG_W-1:0];

endmodule

// ----- design/cosine_taylor_series_unit.sv -----
// each later term: check, 64x64 product in four 32x32 slices, radix-16
//   division by (2k-1)(2k) over 16 steps plus done, then add
// one angle in flight: the next one can be taken from the cycle after the previous
//   result is loaded into the output register
// reset: tolerance returns to 1099512 (about 1e-6), sequencer idle, output empty
module cosine_taylor_series_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  // angle channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [cts_pkg::ANGLE_W-1:0]  in_angle,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [cts_pkg::SUM_W-1:0]    out_cosine,
  output logic [cts_pkg::TERMS_W-1:0]         out_terms_used,
  output logic                                out_limit_hit,
  // tolerance register
  input  logic                                cfg_wr_en,
  input  logic [cts_pkg::TOL_W-1:0]           cfg_wr_data
);

  cts_pkg::cts_state_t state_r, state_nxt;

  // configuration and per-angle working registers
  logic [cts_pkg::TOL_W-1:0]     tol_r;
  logic [cts_pkg::SUM_W-1:0]     thr_r;
  logic [cts_pkg::SUM_W-1:0]     thr_nxt;
  logic [cts_pkg::MAG_W-1:0]     sq_r;
  logic [cts_pkg::MAG_W-1:0]     prev_r;
  logic [cts_pkg::MAG_W-1:0]     mag_r;
  logic signed [cts_pkg::SUM_W-1:0] sum_r;
  logic signed [cts_pkg::SUM_W-1:0] sum_nxt;
  logic [cts_pkg::TERMS_W-1:0]   n_r;
  logic                          limit_r;
  logic [cts_pkg::DEN_W-1:0]     d_r;
  logic [cts_pkg::DEN_W-1:0]     d_nxt;

  // output register
  logic                          out_valid_r;
  logic signed [cts_pkg::SUM_W-1:0] out_cosine_r;
  logic [cts_pkg::TERMS_W-1:0]   out_terms_r;
  logic                          out_limit_r;

  // sequencer strobes
  logic                          in_xfer;
  logic                          out_load;
  logic                          mul_start;
  logic                          div_start;
  logic                          chk_below;
  logic                          chk_limit;
  logic                          chk_first;

  // multiplier, shared by square and term products, and divider
  logic [cts_pkg::ANGLE_W-1:0]   ax;
  logic [cts_pkg::OPND_W-1:0]    mul_a;
  logic [cts_pkg::OPND_W-1:0]    mul_b;
  logic                          mul_done;
  logic [cts_pkg::PROD_W-1:0]    mul_prod;
  logic                          div_done;
  logic [cts_pkg::MAG_W-1:0]     div_quot;

  // magnitude of the angle; the most negative code maps to 2^31
  assign ax = in_angle[cts_pkg::ANGLE_W-1] ? (~in_angle + 1'b1) : in_angle;

  // tolerance in the sum format, rounded up when the sum has fewer fraction bits
  always_comb begin
    if (cts_pkg::SUM_FRAC_BITS >= cts_pkg::TOL_FRAC_BITS) begin
      thr_nxt = cts_pkg::SUM_W'(tol_r) << cts_pkg::THR_UP;
    end else begin
      thr_nxt = (cts_pkg::SUM_W'(tol_r) + ((cts_pkg::SUM_W'(1) << cts_pkg::THR_DN) - 1'b1))
                >> cts_pkg::THR_DN;
    end
  end

  // loop decisions, from the previous term's magnitude against the threshold and from the count
  assign chk_below = {1'b0, prev_r} < thr_r;
  assign chk_limit = n_r >= cts_pkg::TERMS_W'(cts_pkg::MAX_TERMS);
  assign chk_first = n_r == '0;

  // divisor (2k-1)(2k) for term k = n_r
  always_comb begin
    logic [7:0]  n2;
    logic [7:0]  odd;
    logic [15:0] dp;
    n2    = {n_r, 1'b0};
    odd   = n2 - 8'd1;
    dp    = odd * n2;
    d_nxt = dp[cts_pkg::DEN_W-1:0];
  end

  // signed add or subtract of the new term, clamped to the 64-bit range
  always_comb begin
    logic signed [cts_pkg::SUM_W:0] s;
    if (n_r[0]) begin
      s = {sum_r[cts_pkg::SUM_W-1], sum_r} - {2'b00, mag_r};
    end else begin
      s = {sum_r[cts_pkg::SUM_W-1], sum_r} + {2'b00, mag_r};
    end
    if (s[cts_pkg::SUM_W] != s[cts_pkg::SUM_W-1]) begin
      sum_nxt = s[cts_pkg::SUM_W] ? {1'b1, {(cts_pkg::SUM_W-1){1'b0}}}
                                  : {1'b0, {(cts_pkg::SUM_W-1){1'b1}}};
    end else begin
      sum_nxt = s[cts_pkg::SUM_W-1:0];
    end
  end

  // multiplier serves the square of the angle first, then every term product
  always_comb begin
    if (state_r == cts_pkg::ST_IDLE) begin
      mul_a = cts_pkg::OPND_W'(ax);
      mul_b = cts_pkg::OPND_W'(ax);
    end else begin
      mul_a = cts_pkg::OPND_W'(prev_r);
      mul_b = cts_pkg::OPND_W'(sq_r);
    end
  end

  cts_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (mul_prod)
  );

  // product carries 56 fraction bits from the square; drop them on the way in
  cts_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (mul_prod[cts_pkg::SQ_FRAC_BITS+cts_pkg::NUM_W-1:cts_pkg::SQ_FRAC_BITS]),
    .den   (d_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cts_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = cts_pkg::ST_SQ;
      end
      cts_pkg::ST_SQ: begin
        if (mul_done) state_nxt = cts_pkg::ST_CHECK;
      end
      cts_pkg::ST_CHECK: begin
        priority if (chk_below || chk_limit) state_nxt = cts_pkg::ST_FIN;
        else if (chk_first)                   state_nxt = cts_pkg::ST_ADD;
        else                                  state_nxt = cts_pkg::ST_MUL;
      end
      cts_pkg::ST_MUL: begin
        if (mul_done) state_nxt = cts_pkg::ST_DIV;
      end
      cts_pkg::ST_DIV: begin
        if (div_done) state_nxt = cts_pkg::ST_ADD;
      end
      cts_pkg::ST_ADD: begin
        state_nxt = cts_pkg::ST_CHECK;
      end
      cts_pkg::ST_FIN: begin
        if (!out_valid_r || !out_stall) state_nxt = cts_pkg::ST_IDLE;
      end
      default: state_nxt = cts_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall  = (state_r != cts_pkg::ST_IDLE);
    in_xfer   = (state_r == cts_pkg::ST_IDLE) && in_valid;
    mul_start = in_xfer ||
                ((state_r == cts_pkg::ST_CHECK) && !chk_below && !chk_limit && !chk_first);
    div_start = (state_r == cts_pkg::ST_MUL) && mul_done;
    out_load  = (state_r == cts_pkg::ST_FIN) && (!out_valid_r || !out_stall);
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cts_pkg::ST_IDLE;
      tol_r       <= cts_pkg::TOL_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) tol_r <= cfg_wr_data;
      // output register frees on transfer, refills from a finished angle
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      // series starts with a previous term of exactly 1.0
      prev_r  <= cts_pkg::MAG_ONE;
      sum_r   <= '0;
      n_r     <= '0;
      limit_r <= 1'b0;
      thr_r   <= thr_nxt;
    end
    if ((state_r == cts_pkg::ST_SQ) && mul_done) begin
      sq_r <= mul_prod[cts_pkg::MAG_W-1:0];
    end
    if (state_r == cts_pkg::ST_CHECK) begin
      d_r <= d_nxt;
      if (!chk_below && chk_limit) limit_r <= 1'b1;
      if (chk_first) mag_r <= cts_pkg::MAG_ONE;
    end
    if ((state_r == cts_pkg::ST_DIV) && div_done) begin
      mag_r <= div_quot;
    end
    if (state_r == cts_pkg::ST_ADD) begin
      sum_r  <= sum_nxt;
      n_r    <= n_r + 1'b1;
      prev_r <= mag_r;
    end
    if (out_load) begin
      out_cosine_r <= sum_r;
      out_terms_r  <= n_r;
      out_limit_r  <= limit_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cosine     = out_cosine_r;
  assign out_terms_used = out_terms_r;
  assign out_limit_hit  = out_limit_r;

  // limit only ever raised after the full term budget was spent
  a_limit_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_limit_hit |-> out_terms_used == cts_pkg::TERMS_W'(cts_pkg::MAX_TERMS))
    else $error("limit flag with short term count");

  // no term added means an empty sum and no limit flag
  a_empty_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_terms_used == '0 |-> out_cosine == '0 && !out_limit_hit)
    else $error("non-zero result with no terms");

  // multiplier completes only where the sequencer waits for it
  a_mul_owner: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> state_r == cts_pkg::ST_SQ || state_r == cts_pkg::ST_MUL)
    else $error("multiplier result with nobody waiting");

  // divider completes only in its wait state
  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == cts_pkg::ST_DIV)
    else $error("divider result with nobody waiting");

  // an angle transfer always starts the squaring
  a_start_sq: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r == cts_pkg::ST_SQ && n_r == '0)
    else $error("angle taken without starting the series");

endmodule
